FILE: sv/circular_deque_top_defines.svh
// Assertion macros shared by the deque controller and datapath.
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deque assertion failed");
// Next-cycle implication, disabled while reset is held.
`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deque assertion failed");
`else
`define CDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/cdq_pkg.sv
// Types and constants shared by the circular deque modules.
package cdq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef logic signed [VALUE_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]        count_field_t;

  localparam word_t ALL_ONES = '1;

  // Requested action codes.
  typedef enum logic [1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch;
    logic load;
  } cdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
    logic out_valid;
  } cdq_status_t;

endpackage

FILE: sv/cdq_if.sv
// Channel interfaces for the deque requests and results.
interface cdq_in_if import cdq_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  word_t       value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*;;
  logic         valid;
  logic         ready;
  logic         accepted;
  word_t        popped_value;
  logic         is_empty;
  logic         is_full;
  count_field_t entry_count;
  word_t        front_peek;
  word_t        rear_peek;

  modport source (output valid, accepted, popped_value, is_empty, is_full, entry_count,
                  front_peek, rear_peek, input ready);
  modport sink   (input valid, accepted, popped_value, is_empty, is_full, entry_count,
                  front_peek, rear_peek, output ready);
endinterface

FILE: sv/cdq_ctrl.sv
// Controller state machine that sequences one deque request at a time.
`include "circular_deque_top_defines.svh"

module cdq_ctrl import cdq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        out_ready,
  input  cdq_status_t status,
  output cdq_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.need_read ? S_FETCH : S_RESULT;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // The result register must be empty or draining this cycle.
        if (!status.out_valid || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // A transfer on the request side always starts execution next cycle.
  `CDQ_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  // The memory fetch cycle only follows an execute cycle.
  `CDQ_ASSERT_IMP(a_fetch_after_exec, clk, rst_n, state_r == S_FETCH, $past(state_r) == S_EXEC)
  // Requests are only taken while the controller is idle.
  `CDQ_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)

endmodule

FILE: sv/cdq_dp.sv
// Datapath: ring memory, head and tail pointers, count, peek and result registers.
`include "circular_deque_top_defines.svh"

module cdq_dp import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cdq_cmd_t     cmd,
  output cdq_status_t  status,
  input  logic [1:0]   in_action,
  input  word_t        in_value,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         out_accepted,
  output word_t        out_popped_value,
  output logic         out_is_empty,
  output logic         out_is_full,
  output count_field_t out_entry_count,
  output word_t        out_front_peek,
  output word_t        out_rear_peek
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  function automatic ptr_t wrap_inc(ptr_t p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic ptr_t wrap_dec(ptr_t p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  // Ring storage and its registered read port.
  word_t mem [DEPTH];
  word_t rd_data_r;

  // Latched request.
  action_t act_r;
  word_t   val_r;

  // Queue state.
  ptr_t head_r, head_nxt;
  ptr_t tail_r, tail_nxt;
  cnt_t count_r, count_nxt;
  word_t front_r, front_nxt;
  word_t rear_r, rear_nxt;
  logic  acc_r, acc_nxt;
  word_t popped_r, popped_nxt;
  logic  fetch_front_r, fetch_front_nxt;

  // Result register.
  logic         out_valid_r;
  logic         out_accepted_r;
  word_t        out_popped_r;
  logic         out_empty_r;
  logic         out_full_r;
  count_field_t out_count_r;
  word_t        out_front_r;
  word_t        out_rear_r;

  logic full;
  logic empty;
  logic is_pop;
  logic pop_exec;
  logic mem_we;
  ptr_t mem_wa;
  logic mem_re;
  ptr_t mem_ra;
  logic [CW+COUNT_W-1:0] count_ext;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign is_pop   = (act_r == ACT_POP_FRONT) || (act_r == ACT_POP_REAR);
  assign pop_exec = cmd.exec && is_pop && !empty;

  assign status.need_read = is_pop && !empty;
  assign status.out_valid = out_valid_r;

  // Execute step: pointer and count update, memory access and peek tracking.
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    acc_nxt         = 1'b0;
    popped_nxt      = ALL_ONES;
    fetch_front_nxt = fetch_front_r;
    mem_we          = 1'b0;
    mem_wa          = tail_r;
    mem_re          = 1'b0;
    mem_ra          = head_r;
    unique case (act_r)
      ACT_PUSH_REAR: begin
        if (!full) begin
          mem_we    = 1'b1;
          mem_wa    = tail_r;
          tail_nxt  = wrap_inc(tail_r);
          count_nxt = count_r + CW'(1);
          rear_nxt  = val_r;
          if (empty) begin
            front_nxt = val_r;
          end
          acc_nxt = 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (!full) begin
          mem_we    = 1'b1;
          mem_wa    = wrap_dec(head_r);
          head_nxt  = wrap_dec(head_r);
          count_nxt = count_r + CW'(1);
          front_nxt = val_r;
          if (empty) begin
            rear_nxt = val_r;
          end
          acc_nxt = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty) begin
          popped_nxt      = front_r;
          head_nxt        = wrap_inc(head_r);
          count_nxt       = count_r - CW'(1);
          mem_re          = 1'b1;
          mem_ra          = wrap_inc(head_r);
          fetch_front_nxt = 1'b1;
          acc_nxt         = 1'b1;
        end
      end
      ACT_POP_REAR: begin
        if (!empty) begin
          popped_nxt      = rear_r;
          tail_nxt        = wrap_dec(tail_r);
          count_nxt       = count_r - CW'(1);
          mem_re          = 1'b1;
          mem_ra          = wrap_dec(wrap_dec(tail_r));
          fetch_front_nxt = 1'b0;
          acc_nxt         = 1'b1;
        end
      end
    endcase
  end

  // Ring memory: one write or one read per execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_wa] <= val_r;
    end
    if (cmd.exec && mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Request latch, peek words and step outcome.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      val_r <= in_value;
    end
    if (cmd.exec) begin
      front_r       <= front_nxt;
      rear_r        <= rear_nxt;
      acc_r         <= acc_nxt;
      popped_r      <= popped_nxt;
      fetch_front_r <= fetch_front_nxt;
    end else if (cmd.fetch) begin
      if (fetch_front_r) begin
        front_r <= rd_data_r;
      end else begin
        rear_r <= rd_data_r;
      end
    end
  end

  // Result valid flag: set on load, cleared when the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_r};

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_accepted_r <= acc_r;
      out_popped_r   <= popped_r;
      out_empty_r    <= empty;
      out_full_r     <= full;
      out_count_r    <= count_ext[COUNT_W-1:0];
      out_front_r    <= empty ? ALL_ONES : front_r;
      out_rear_r     <= empty ? ALL_ONES : rear_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_popped_value = out_popped_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;
  assign out_entry_count  = out_count_r;
  assign out_front_peek   = out_front_r;
  assign out_rear_peek    = out_rear_r;

  // The count never exceeds the ring size.
  `CDQ_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  // A push into a full ring leaves the count alone.
  `CDQ_ASSERT_NXT(a_full_push_hold, clk, rst_n, cmd.exec && !is_pop && full, $stable(count_r))
  // An accepted pop removes exactly one entry.
  `CDQ_ASSERT_NXT(a_pop_count, clk, rst_n, pop_exec, count_r == $past(count_r) - CW'(1))

endmodule

FILE: sv/circular_deque_top.sv
// Top level of the circular deque: controller, datapath and channel hookup.
//
//  Channel  Direction  Handshake      Payload
//  in_if    sink       valid / ready  action, value
//  out_if   source     valid / ready  accepted, popped_value, is_empty, is_full,
//                                     entry_count, front_peek, rear_peek
//
// One request is in flight at a time: accept, execute and load run for pushes and rejected
// actions, and accepted pops add a ring read step for the new front or rear word.
// The result is loaded once the output register is empty or draining.
// A new request is taken while the previous result still waits in the output register;
// a stalled result then holds the controller in its result state until the register frees.
// Reset (rst_n low, synchronous) empties the deque; the ring contents are not cleared.
module circular_deque_top import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  cdq_in_if.sink    in_if,
  cdq_out_if.source out_if
);

  cdq_cmd_t    cmd;
  cdq_status_t status;

  // Sequencing of each request.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage, pointers and result register.
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_action        (in_if.action),
    .in_value         (in_if.value),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_accepted     (out_if.accepted),
    .out_popped_value (out_if.popped_value),
    .out_is_empty     (out_if.is_empty),
    .out_is_full      (out_if.is_full),
    .out_entry_count  (out_if.entry_count),
    .out_front_peek   (out_if.front_peek),
    .out_rear_peek    (out_if.rear_peek)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the circular deque top level.
`timescale 1ns / 1ps

module tb;
  import cdq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1225;
  localparam int PHASE_ITEMS  = 420;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTS   = 60;

  // One request to the deque.
  typedef struct {
    action_t act;
    word_t   val;
  } deque_request_t;

  // Result fields as the deque reports them after one action.
  typedef struct {
    logic         accepted;
    word_t        popped_value;
    logic         is_empty;
    logic         is_full;
    count_field_t entry_count;
    word_t        front_peek;
    word_t        rear_peek;
  } deque_result_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  circular_deque_top #(.DEPTH(DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  deque_request_t request_queue[$];
  deque_result_t  expected_results[$];
  int             error_count = 0;
  int             requests_taken = 0;
  int             results_seen = 0;
  int             quiet_cycles = 0;

  // Shadow copy of the deque contents.
  word_t shadow_ring[DEPTH];
  int    shadow_head = 0;
  int    shadow_tail = 0;
  int    shadow_count = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one action to the shadow deque and returns the result it yields.
  function automatic deque_result_t apply_action(action_t act, word_t val);
    deque_result_t res;
    res.accepted     = 1'b0;
    res.popped_value = ALL_ONES;
    case (act)
      ACT_PUSH_REAR: begin
        if (shadow_count < DEPTH) begin
          shadow_ring[shadow_tail] = val;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
          res.accepted = 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (shadow_count < DEPTH) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = val;
          shadow_count++;
          res.accepted = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_count > 0) begin
          res.popped_value = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
          res.accepted = 1'b1;
        end
      end
      default: begin
        if (shadow_count > 0) begin
          shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
          res.popped_value = shadow_ring[shadow_tail];
          shadow_count--;
          res.accepted = 1'b1;
        end
      end
    endcase
    res.is_empty    = (shadow_count == 0);
    res.is_full     = (shadow_count == DEPTH);
    res.entry_count = count_field_t'(shadow_count);
    if (shadow_count != 0) begin
      res.front_peek = shadow_ring[shadow_head];
      res.rear_peek  = shadow_ring[(shadow_tail + DEPTH - 1) % DEPTH];
    end else begin
      res.front_peek = ALL_ONES;
      res.rear_peek  = ALL_ONES;
    end
    return res;
  endfunction

  // Idle percentages follow the traffic phase: sender-light, receiver-light, then none.
  function automatic int sender_gap_pct();
    if (requests_taken < PHASE_ITEMS) return 32;
    if (requests_taken < 2 * PHASE_ITEMS) return 70;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (results_seen < PHASE_ITEMS) return 70;
    if (results_seen < 2 * PHASE_ITEMS) return 32;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_request(input action_t act, input word_t val);
    deque_request_t req;
    req.act = act;
    req.val = val;
    request_queue = {request_queue, req};
  endtask

  // Mostly random words, with the extremes mixed in.
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return ALL_ONES;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Driver: presents the next queued request, holding it until its transfer.
  always @(posedge clk) begin : drive_requests
    deque_request_t next_req;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (request_queue.size() > 0 && $urandom_range(99) >= sender_gap_pct()) begin
        next_req = request_queue[0];
        request_queue.delete(0);
        in_if.valid  <= 1'b1;
        in_if.action <= next_req.act;
        in_if.value  <= next_req.val;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // Monitor: checks each result transfer, then predicts for each request transfer.
  always @(posedge clk) begin : watch_channels
    deque_result_t want;
    deque_result_t pred;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no request pending");
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_if.accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %0b expected %0b",
                                      out_if.accepted, want.accepted));
          if (out_if.popped_value !== want.popped_value)
            report_mismatch($sformatf("popped_value got %0h expected %0h",
                                      out_if.popped_value, want.popped_value));
          if (out_if.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %0b expected %0b",
                                      out_if.is_empty, want.is_empty));
          if (out_if.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %0b expected %0b",
                                      out_if.is_full, want.is_full));
          if (out_if.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      out_if.entry_count, want.entry_count));
          if (out_if.front_peek !== want.front_peek)
            report_mismatch($sformatf("front_peek got %0h expected %0h",
                                      out_if.front_peek, want.front_peek));
          if (out_if.rear_peek !== want.rear_peek)
            report_mismatch($sformatf("rear_peek got %0h expected %0h",
                                      out_if.rear_peek, want.rear_peek));
        end
      end
      if (in_if.valid && in_if.ready) begin
        requests_taken <= requests_taken + 1;
        pred = apply_action(action_t'(in_if.action), in_if.value);
        expected_results = {expected_results, pred};
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : run_test
    int push_pct;
    in_if.valid  = 1'b0;
    in_if.action = ACT_PUSH_REAR;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    rst_n        = 1'b0;

    // Directed: pops on an empty deque, extremes at both ends, fill to full,
    // pushes refused while full, then one pop.
    queue_request(ACT_POP_FRONT, 32'sh1234_5678);
    queue_request(ACT_POP_REAR, ALL_ONES);
    queue_request(ACT_PUSH_REAR, 32'sh7fff_ffff);
    queue_request(ACT_PUSH_FRONT, 32'sh8000_0000);
    queue_request(ACT_POP_REAR, '0);
    queue_request(ACT_POP_FRONT, '0);
    for (int i = 0; i < DEPTH; i++) begin
      queue_request((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_REAR,
                    (i == 0) ? word_t'('0) : (i == 1) ? ALL_ONES : word_t'($urandom));
    end
    queue_request(ACT_PUSH_REAR, 32'sh5555_5555);
    queue_request(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
    queue_request(ACT_POP_FRONT, '0);

    // Random: runs that lean toward filling, draining or neither, so the deque
    // keeps crossing between empty and full with random words.
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < push_pct)
        queue_request($urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, pick_word());
      else
        queue_request($urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT, pick_word());
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (request_queue.size() == 0 && !in_if.valid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_if.sv
sv/cdq_ctrl.sv
sv/cdq_dp.sv
sv/circular_deque_top.sv
tb/tb.sv
